// ===== hdl/fsgl_pkg.sv =====
// ----------------------------------------------------------------------------
// fsgl_pkg
// Shared widths, defaults, register indexes and the search token of the
// sector geometry lookup.
// ----------------------------------------------------------------------------
package fsgl_pkg;

	// Defaults of the top level parameters
	localparam int MAP_BITS_DEF       = 32;
	localparam int UNIT_LOG2_DEF      = 12;
	localparam int MAX_WIDTH_LOG2_DEF = 2;

	// Largest map the token has to serve
	localparam int MAP_BITS_MAX = 64;

	// Field widths
	localparam int OFF_W     = 32;
	localparam int SIZE_W    = 20;
	localparam int UNIFORM_W = 19;
	localparam int ADDR_W    = 24;
	localparam int MAP_W     = 32;
	localparam int WLOG_W    = 2;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UNIFORM   = 3'd0,
		REG_TOTAL     = 3'd1,
		REG_BOOT_LOW  = 3'd2,
		REG_BOOT_HIGH = 3'd3,
		REG_MAP       = 3'd4,
		REG_WLOG      = 3'd5
	} cfg_reg_t;

	// Token fields, sized for the largest map
	localparam int TOK_IDX_W = $clog2(MAP_BITS_MAX);
	localparam int TOK_CNT_W = $clog2(MAP_BITS_MAX + 1);

	// Search token handed from cell to cell
	typedef struct packed {
		logic                 valid;
		logic                 done;   // sector end already found
		logic [TOK_IDX_W-1:0] idx;    // unit index being looked up
		logic [TOK_CNT_W-1:0] gap;    // units since the previous mark
		logic [TOK_CNT_W-1:0] units;  // sector size in units once done
	} tok_t;

endpackage

// ===== hdl/fsgl_cell.sv =====
// ----------------------------------------------------------------------------
// fsgl_cell
// One map position: holds its boot map bit and advances the search token.
// ----------------------------------------------------------------------------
module fsgl_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            map_we,
	input  logic            map_bit,
	input  fsgl_pkg::tok_t  tok_i,
	output fsgl_pkg::tok_t  tok_o
);
	import fsgl_pkg::*;

	logic                 mark_q;
	logic                 valid_q;
	tok_t                 tok_q;
	logic [TOK_CNT_W-1:0] gap_inc;
	logic                 hit;

	// distance from the previous mark to this position
	assign gap_inc = tok_i.gap + TOK_CNT_W'(1);
	assign hit     = mark_q && !tok_i.done && (TOK_IDX_W'(CELL_IDX) >= tok_i.idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (map_we) begin
				mark_q <= map_bit;
			end
			valid_q <= tok_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q.valid <= 1'b0;
		tok_q.idx   <= tok_i.idx;
		tok_q.done  <= tok_i.done | hit;
		tok_q.units <= hit ? gap_inc : tok_i.units;
		tok_q.gap   <= mark_q ? '0 : gap_inc;
	end

	always_comb begin
		tok_o       = tok_q;
		tok_o.valid = valid_q;
	end

endmodule

// ===== hdl/flash_sector_geometry_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// flash_sector_geometry_lookup_unit
// Maps a flash byte offset to the size and aligned base of its erase sector.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_stall carries byte_offset. A transaction is
//    taken when in_valid is high and in_stall is low.
//  - Output channel out_valid/out_stall carries sector_bytes, sector_start,
//    in_boot_area and found, held steady while out_stall is high.
//  - Configuration writes use cfg_valid/cfg_ready with cfg_index/cfg_data;
//    cfg_ready is always high. Write registers only while the block is idle.
//  - Every lookup walks a token through a row of MAP_BITS cells, one cell
//    per cycle, each cell holding one boot map bit. One lookup is in flight
//    at a time: a new offset is taken only once the last result has moved
//    into the output register.
//  - The finished result sits in the output register; the next offset is
//    taken while it waits. A stalled receiver holds a later result in a
//    one-entry holding register, and input stays stalled until it moves.
//  - Reset clears the configuration (width_log2 to 2), empties the chain
//    and drops out_valid.
// ----------------------------------------------------------------------------
module flash_sector_geometry_lookup_unit #(
	parameter int MAP_BITS       = fsgl_pkg::MAP_BITS_DEF,
	parameter int UNIT_LOG2      = fsgl_pkg::UNIT_LOG2_DEF,
	parameter int MAX_WIDTH_LOG2 = fsgl_pkg::MAX_WIDTH_LOG2_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fsgl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fsgl_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [fsgl_pkg::OFF_W-1:0]        byte_offset,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [fsgl_pkg::SIZE_W-1:0]       sector_bytes,
	output logic [fsgl_pkg::OFF_W-1:0]        sector_start,
	output logic                              in_boot_area,
	output logic                              found
);
	import fsgl_pkg::*;

	localparam int SHW   = $clog2(UNIT_LOG2 + MAX_WIDTH_LOG2 + 1);
	localparam int SZ_A  = TOK_CNT_W + UNIT_LOG2 + MAX_WIDTH_LOG2;
	localparam int SZ_B  = (SZ_A > UNIFORM_W) ? SZ_A : UNIFORM_W;
	localparam int SZW   = (SZ_B > SIZE_W) ? SZ_B : SIZE_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

	// configuration
	logic [UNIFORM_W-1:0] uniform_q;
	logic [ADDR_W-1:0]    total_q;
	logic [ADDR_W-1:0]    boot_low_q;
	logic [ADDR_W-1:0]    boot_high_q;
	logic [WLOG_W-1:0]    wlog_q;

	state_t               state_q;

	// lookup context
	logic [OFF_W-1:0]     off_q;
	logic                 in_boot_q;
	logic                 use_boot_q;
	logic                 past_end_q;
	logic                 idx_ok_q;
	logic [SHW-1:0]       shift_q;

	// holding register
	logic [SZW-1:0]       res_size_q;
	logic [OFF_W-1:0]     res_start_q;
	logic                 res_boot_q;

	// output register
	logic                 out_valid_q;
	logic [SIZE_W-1:0]    out_bytes_q;
	logic [OFF_W-1:0]     out_start_q;
	logic                 out_boot_q;
	logic                 out_found_q;

	logic                 cfg_we;
	logic                 in_acc;
	logic                 out_free;
	logic [WLOG_W-1:0]    wlog_eff;
	logic [SHW-1:0]       shift;
	logic                 in_boot;
	logic                 use_boot;
	logic                 past_end;
	logic [ADDR_W-1:0]    boot_rel;
	logic [ADDR_W-1:0]    unit_idx;
	logic                 idx_ok;
	logic [TOK_CNT_W-1:0] units;
	logic [SZW-1:0]       size;
	logic [OFF_W-1:0]     start;

	tok_t                 tok [MAP_BITS+1];
	tok_t                 tail;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;

	// ---- front: range tests and unit index ----
	assign wlog_eff = (wlog_q > WLOG_W'(MAX_WIDTH_LOG2)) ? WLOG_W'(MAX_WIDTH_LOG2) : wlog_q;
	assign shift    = SHW'(UNIT_LOG2) + SHW'(wlog_eff);
	assign in_boot  = (byte_offset >= OFF_W'(boot_low_q)) &&
	                  (byte_offset <  OFF_W'(boot_high_q));
	assign use_boot = in_boot && (uniform_q >= UNIFORM_W'(1 << UNIT_LOG2));
	assign past_end = (byte_offset >= OFF_W'(total_q));
	// only meaningful inside the boot area, where the offset fits 24 bits
	assign boot_rel = byte_offset[ADDR_W-1:0] - boot_low_q;
	assign unit_idx = boot_rel >> shift;
	assign idx_ok   = (unit_idx < ADDR_W'(MAP_BITS));

	always_comb begin
		tok[0]       = '0;
		tok[0].valid = in_acc;
		tok[0].idx   = unit_idx[TOK_IDX_W-1:0];
	end

	// ---- cell row ----
	for (genvar i = 0; i < MAP_BITS; i++) begin : g_cell
		logic map_bit;
		if (i < MAP_W) begin : g_used
			assign map_bit = cfg_data[i];
		end else begin : g_unused
			assign map_bit = 1'b0;
		end

		fsgl_cell #(
			.CELL_IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.map_we  (cfg_we && (cfg_index == REG_MAP)),
			.map_bit (map_bit),
			.tok_i   (tok[i]),
			.tok_o   (tok[i+1])
		);
	end

	assign tail = tok[MAP_BITS];

	// ---- back: size and aligned base ----
	assign units = idx_ok_q ? tail.units : '0;

	always_comb begin
		if (use_boot_q) begin
			size = SZW'(units) << shift_q;
		end else if (past_end_q) begin
			size = '0;
		end else begin
			size = SZW'(uniform_q);
		end
	end

	assign start = (size != '0) ? (off_q & ~(OFF_W'(size) - OFF_W'(1))) : '1;

	// ---- configuration registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uniform_q   <= '0;
			total_q     <= '0;
			boot_low_q  <= '0;
			boot_high_q <= '0;
			wlog_q      <= WLOG_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UNIFORM:   uniform_q   <= cfg_data[UNIFORM_W-1:0];
				REG_TOTAL:     total_q     <= cfg_data[ADDR_W-1:0];
				REG_BOOT_LOW:  boot_low_q  <= cfg_data[ADDR_W-1:0];
				REG_BOOT_HIGH: boot_high_q <= cfg_data[ADDR_W-1:0];
				REG_WLOG:      wlog_q      <= cfg_data[WLOG_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- lookup control and output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a finished lookup reloads the output register below
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (tail.valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			off_q      <= byte_offset;
			in_boot_q  <= in_boot;
			use_boot_q <= use_boot;
			past_end_q <= past_end;
			idx_ok_q   <= idx_ok;
			shift_q    <= shift;
		end
		if (state_q == ST_WALK && tail.valid) begin
			res_size_q  <= size;
			res_start_q <= start;
			res_boot_q  <= in_boot_q;
		end
		if (state_q == ST_DONE && out_free) begin
			out_bytes_q <= res_size_q[SIZE_W-1:0];
			out_start_q <= res_start_q;
			out_boot_q  <= res_boot_q;
			out_found_q <= (res_size_q != '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign sector_bytes = out_bytes_q;
	assign sector_start = out_start_q;
	assign in_boot_area = out_boot_q;
	assign found        = out_found_q;

	// ---- assertions ----
	a_tail_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> (state_q == ST_WALK))
		else $error("token left the cell row outside a walk");

	a_none_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (sector_start == '1))
		else $error("missing sector without all-ones base");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result presented without a finished lookup");

endmodule

// ===== bench/flash_sector_geometry_lookup_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flash_sector_geometry_lookup_unit_tb
// Self-checking bench: directed and randomized offset lookups over many
// sector layouts. Results are compared in order against a behavioral
// predictor, with random gaps on the input side and random output stalls.
// ----------------------------------------------------------------------------
module flash_sector_geometry_lookup_unit_tb;
	import fsgl_pkg::*;

	localparam logic [2:0] REG_SPARE_6    = 3'd6;
	localparam logic [2:0] REG_SPARE_7    = 3'd7;

	localparam int UNIT_BYTES    = 1 << fsgl_pkg::UNIT_LOG2_DEF;
	localparam int RANDOM_ITEMS  = 1850;
	localparam int STALL_PERCENT = 34;
	localparam int HANG_LIMIT    = 3000;

	typedef struct packed {
		logic [fsgl_pkg::SIZE_W-1:0] bytes;
		logic [fsgl_pkg::OFF_W-1:0]  start;
		logic                        boot;
		logic                        hit;
	} sector_info_t;

	logic                            clk         = 1'b0;
	logic                            arst_n      = 1'b0;
	logic                            cfg_valid   = 1'b0;
	logic                            cfg_ready;
	logic [fsgl_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [fsgl_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
	logic                            in_valid    = 1'b0;
	logic                            in_stall;
	logic [fsgl_pkg::OFF_W-1:0]      byte_offset = '0;
	logic                            out_valid;
	logic                            out_stall   = 1'b0;
	logic [fsgl_pkg::SIZE_W-1:0]     sector_bytes;
	logic [fsgl_pkg::OFF_W-1:0]      sector_start;
	logic                            in_boot_area;
	logic                            found;

	// Shadow copy of the layout registers
	logic [fsgl_pkg::UNIFORM_W-1:0] lay_uniform = '0;
	logic [fsgl_pkg::ADDR_W-1:0]    lay_total   = '0;
	logic [fsgl_pkg::ADDR_W-1:0]    lay_low     = '0;
	logic [fsgl_pkg::ADDR_W-1:0]    lay_high    = '0;
	logic [fsgl_pkg::MAP_W-1:0]     lay_map     = '0;
	logic [fsgl_pkg::WLOG_W-1:0]    lay_wlog    = 2'd2;

	sector_info_t pending_sectors[$];
	int           err_count  = 0;
	int           hang_count = 0;
	bit           idle_en    = 1'b1;

	flash_sector_geometry_lookup_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.byte_offset  (byte_offset),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sector_bytes (sector_bytes),
		.sector_start (sector_start),
		.in_boot_area (in_boot_area),
		.found        (found)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(negedge clk) begin
		out_stall = idle_en && ($urandom_range(99) < STALL_PERCENT);
	end

	function automatic sector_info_t locate_sector(input logic [31:0] off);
		sector_info_t r;
		int unsigned  shift;
		logic [63:0]  idx;
		logic [63:0]  units;
		logic [63:0]  size;
		int           prev;
		shift = fsgl_pkg::UNIT_LOG2_DEF + ((lay_wlog > 2) ? 2 : lay_wlog);
		r.boot = (off >= lay_low) && (off < lay_high);
		size = '0;
		if (r.boot && lay_uniform >= UNIT_BYTES) begin
			idx = (64'(off) - 64'(lay_low)) >> shift;
			prev = -1;
			units = '0;
			// sector ends at the first mark at or above the unit index
			for (int i = 0; i < fsgl_pkg::MAP_BITS_DEF; i++) begin
				if (lay_map[i] && units == 0) begin
					if (i >= idx)
						units = i - prev;
					else
						prev = i;
				end
			end
			size = units << shift;
		end else if (off >= lay_total) begin
			size = '0;
		end else begin
			size = lay_uniform;
		end
		r.bytes = size[fsgl_pkg::SIZE_W-1:0];
		r.start = (size != 0) ? (off & ~(size[31:0] - 32'd1)) : '1;
		r.hit = (size != 0);
		return r;
	endfunction

	task automatic send_offset(input logic [31:0] off);
		@(negedge clk);
		while (idle_en && $urandom_range(99) < STALL_PERCENT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		byte_offset = off;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_sectors.push_back(locate_sector(off));
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_sectors.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_UNIFORM:   lay_uniform = data[fsgl_pkg::UNIFORM_W-1:0];
			REG_TOTAL:     lay_total = data[fsgl_pkg::ADDR_W-1:0];
			REG_BOOT_LOW:  lay_low = data[fsgl_pkg::ADDR_W-1:0];
			REG_BOOT_HIGH: lay_high = data[fsgl_pkg::ADDR_W-1:0];
			REG_MAP:       lay_map = data[fsgl_pkg::MAP_W-1:0];
			REG_WLOG:      lay_wlog = data[fsgl_pkg::WLOG_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Sets bits above the register width now and then; the block drops them
	function automatic logic [31:0] with_junk(input logic [31:0] data, input int width,
		input bit junk);
		logic [31:0] extra;
		extra = (width >= 32) ? 32'd0 : ($urandom << width);
		return (junk && $urandom_range(3) == 0) ? (data | extra) : data;
	endfunction

	task automatic set_layout(input logic [31:0] uni, tot, lo, hi, map, wl,
		input bit junk = 1'b0);
		drain_results();
		write_reg(REG_UNIFORM, with_junk(uni, fsgl_pkg::UNIFORM_W, junk));
		write_reg(REG_TOTAL, with_junk(tot, fsgl_pkg::ADDR_W, junk));
		write_reg(REG_BOOT_LOW, with_junk(lo, fsgl_pkg::ADDR_W, junk));
		write_reg(REG_BOOT_HIGH, with_junk(hi, fsgl_pkg::ADDR_W, junk));
		write_reg(REG_MAP, map);
		write_reg(REG_WLOG, with_junk(wl, fsgl_pkg::WLOG_W, junk));
	endtask

	function automatic logic [31:0] pick_offset();
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] tot;
		int          r;
		lo = lay_low;
		hi = lay_high;
		tot = lay_total;
		r = $urandom_range(99);
		if (r < 45 && hi > lo)
			return lo + $urandom_range(0, hi - lo - 1);
		if (r < 75 && tot != 0)
			return $urandom_range(0, tot - 1);
		if (r < 87) begin
			case ($urandom_range(5))
				0: return lo;
				1: return lo - 1;
				2: return hi;
				3: return hi - 1;
				4: return tot;
				default: return tot - 1;
			endcase
		end
		return $urandom;
	endfunction

	// Out-of-order or missing results would show up here first
	always @(posedge clk) begin : check_result
		sector_info_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sectors.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("%0t: unexpected result bytes=%h start=%h boot=%b found=%b",
						$realtime, sector_bytes, sector_start, in_boot_area, found);
			end else begin
				want = pending_sectors.pop_front();
				if (sector_bytes !== want.bytes || sector_start !== want.start ||
					in_boot_area !== want.boot || found !== want.hit) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t: mismatch exp %h %h %b %b, got %h %h %b %b",
							$realtime, want.bytes, want.start, want.boot, want.hit,
							sector_bytes, sector_start, in_boot_area, found);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
				hang_count <= 0;
			else
				hang_count <= hang_count + 1;
			if (hang_count >= HANG_LIMIT) begin
				$display("flash_sector_geometry_lookup_unit_tb: errors");
				$finish;
			end
		end
	end

	task automatic test_after_reset();
		send_offset(32'h0000_0000);
		send_offset(32'hFFFF_FFFF);
	endtask

	task automatic test_uniform_array();
		set_layout(32'h1_0000, 32'h80_0000, 0, 0, 0, 2);
		send_offset(32'h0000_0000);
		send_offset(32'h007F_FFFF);
		send_offset(32'h0080_0000);
		send_offset(32'h0001_2345);
	endtask

	// Marks at units 0, 1, 4 and 31: sectors of 1, 1, 3 and 27 units
	task automatic test_boot_sectors();
		logic [31:0] lo;
		lo = 32'h4000;
		set_layout(32'h1_0000, 32'h80_0000, lo, lo + 40 * UNIT_BYTES, 32'h8000_0013, 0);
		send_offset(lo);
		send_offset(lo + UNIT_BYTES);
		send_offset(lo + 2 * UNIT_BYTES + 32'h123);
		send_offset(lo + 31 * UNIT_BYTES);
		send_offset(lo + 32 * UNIT_BYTES);        // past the last map bit
		send_offset(lo + 40 * UNIT_BYTES - 1);
		send_offset(lo + 40 * UNIT_BYTES);
		send_offset(lo - 1);
	endtask

	// Width code 3 is clamped to 2
	task automatic test_bus_width();
		set_layout(32'h4_0000, 32'hFF_FFFF, 0, 32'h10_0000, 32'hFFFF_FFFF, 3);
		send_offset(32'h0000_3FFF);
		send_offset(32'h0000_4000);
	endtask

	task automatic test_odd_sizes();
		// uniform below one unit: boot area looked up as plain array
		set_layout(32'h800, 32'h10_0000, 32'h4000, 32'h2_0000, 32'hFFFF_FFFF, 0);
		send_offset(32'h0000_5000);
		// zero uniform size below the end
		set_layout(0, 32'h10_0000, 0, 0, 0, 1);
		send_offset(32'h0000_0100);
		// largest uniform code, not a power of two
		set_layout(32'h7_FFFF, 32'hFF_FFFF, 0, 0, 0, 2);
		send_offset(32'h00FF_FFFE);
		// reversed boot range
		set_layout(32'h1_0000, 32'h80_0000, 32'h2_0000, 32'h1_0000, 32'hFFFF_FFFF, 2);
		drain_results();
		write_reg(REG_SPARE_6, $urandom);
		write_reg(REG_SPARE_7, 32'hFFFF_FFFF);
		send_offset(32'h0001_8000);
	endtask

	task automatic test_random_layouts();
		int          sent;
		int          phase;
		int          n;
		logic [31:0] wl;
		logic [31:0] unit;
		logic [31:0] uni;
		logic [31:0] tot;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] map;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			idle_en = !(phase >= 6 && phase < 10);
			wl = $urandom_range(0, 3);
			unit = UNIT_BYTES << ((wl > 2) ? 2 : wl);
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: uni = 32'd1 << $urandom_range(12, 18);
				6:                uni = 32'd1 << $urandom_range(0, 11);
				7:                uni = 0;
				8:                uni = $urandom_range(0, 32'h7_FFFF);
				default:          uni = 32'h7_FFFF;
			endcase
			case ($urandom_range(5))
				0, 1, 2: tot = 32'd1 << $urandom_range(16, 23);
				3:       tot = 32'hFF_FFFF;
				4:       tot = $urandom_range(0, 32'hFF_FFFF);
				default: tot = 0;
			endcase
			case ($urandom_range(3))
				0:       lo = 0;
				3:       lo = $urandom_range(0, 32'hFF_FFFF);
				default: lo = $urandom_range(0, 63) * unit;
			endcase
			case ($urandom_range(7))
				6:       hi = $urandom_range(0, 32'hFF_FFFF);
				7:       hi = lo;
				default: hi = lo + $urandom_range(1, 36) * unit;
			endcase
			if (hi > 32'hFF_FFFF)
				hi = 32'hFF_FFFF;
			case ($urandom_range(5))
				0, 1: map = $urandom;
				2:    map = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31)) |
					(32'd1 << $urandom_range(0, 31));
				3:    map = 0;
				4:    map = 32'hFFFF_FFFF;
				default: map = 32'd1 << $urandom_range(0, 31);
			endcase
			if (phase == 0) begin
				uni = 32'h4_0000;
				tot = 32'hFF_FFFF;
				lo = 0;
				hi = 32'hFF_FFFF;
				map = 32'hFFFF_FFFF;
				wl = 2;
			end else if (phase == 1) begin
				uni = UNIT_BYTES;
				tot = 32'h1_0000;
				lo = 0;
				hi = 32'hFF_FFFF;
				map = 0;
				wl = 0;
			end
			set_layout(uni, tot, lo, hi, map, wl, phase > 1);
			n = $urandom_range(40, 110);
			repeat (n)
				send_offset(pick_offset());
			sent += n;
			phase++;
		end
		idle_en = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_after_reset();
		test_uniform_array();
		test_boot_sectors();
		test_bus_width();
		test_odd_sizes();
		test_random_layouts();
		drain_results();
		repeat (fsgl_pkg::MAP_BITS_DEF + 8) @(posedge clk);
		if (err_count == 0)
			$display("flash_sector_geometry_lookup_unit_tb: clean");
		else
			$display("flash_sector_geometry_lookup_unit_tb: errors");
		$finish;
	end

endmodule
